/* hw/rtl/dltq_pkg.sv */
// dltq_pkg: shared types, codes and saturation helper for the delta list timer queue
// used by dltq_ctrl, dltq_dpath and delta_list_timer_queue_unit
package dltq_pkg;

  localparam int RESULT_LIMIT = 16;

  localparam logic [1:0] OP_SCHED  = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_ELAPSE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [3:0]         id;
    logic signed [31:0] delta;
    logic [30:0]        req;
  } slot_t;

  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_START,
    ACT_RD_K,
    ACT_RD_KM1,
    ACT_EV_SCH,
    ACT_EV_CAN,
    ACT_EV_FIRE,
    ACT_K_ONE,
    ACT_MV_DN_PREP,
    ACT_MV_DN,
    ACT_INS,
    ACT_MV_UP_PREP,
    ACT_MV_UP,
    ACT_DEL,
    ACT_HEAD_WR,
    ACT_FIRE_PREP,
    ACT_EMIT,
    ACT_EMIT_F,
    ACT_CMP_PREP,
    ACT_CMP,
    ACT_CMP_DONE
  } act_e;

  typedef struct packed {
    act_e       act;
    logic [1:0] st;
  } cmd_t;

  typedef struct packed {
    logic is_sched;
    logic is_cancel;
    logic is_elapse;
    logic cnt_zero;
    logic full;
    logic dup;
    logic found;
    logic no_fire;
    logic k_lt_cnt;
    logic k_gt_pos;
    logic fire_done;
    logic last_fire;
    logic out_free;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/dltq_dpath.sv */
// dltq_dpath: slot memory, queue count, scan registers and result register
// driven by commands from dltq_ctrl; depends on dltq_pkg
module dltq_dpath import dltq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic [1:0]          opcode_i,
  input  logic [3:0]          timer_id_i,
  input  logic [30:0]         amount_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic                fired_o,
  output logic [3:0]          fired_id_o,
  output logic signed [31:0]  fired_time_o,
  output logic signed [31:0]  head_delta_o,
  output logic                head_changed_o,
  output logic                last_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] One = CW'(1);
  localparam logic [CW-1:0] Full = CW'(QUEUE_DEPTH);

  slot_t mem_q [QUEUE_DEPTH];
  slot_t rdata_q;

  logic [15:0]        prec_q;
  logic [1:0]         op_q;
  logic [3:0]         id_q;
  logic [30:0]        amt_q;
  logic [CW-1:0]      k_q, cnt_q, pos_q, fcnt_q;
  logic signed [31:0] dt_q, newd_q, nhead_q, head_q;
  logic               found_q, dup_q, stop_q, hchg_q;

  logic               out_valid_q, fired_q, last_q, hchg_out_q;
  logic [1:0]         status_q;
  logic [3:0]         fid_q;
  logic signed [31:0] ftime_q, hout_q;

  logic               re, we;
  logic [AW-1:0]      raddr, waddr;
  slot_t              wdata;
  logic signed [31:0] newd_in, nhead_calc, nh_sat;
  logic signed [32:0] prec_ext;

  assign prec_ext = $signed({17'b0, prec_q});
  assign newd_in  = sat32({{2{head_q[31]}}, head_q} - {3'b0, amount_i});
  assign nh_sat   = sat32({{2{rdata_q.delta[31]}}, rdata_q.delta} + {{2{newd_q[31]}}, newd_q});
  assign nhead_calc = nh_sat[31] ? 32'sd0 : nh_sat;

  always_comb begin
    re    = 1'b0;
    we    = 1'b0;
    raddr = AW'(k_q);
    waddr = AW'(k_q);
    wdata = rdata_q;
    case (cmd_i.act)
      ACT_RD_K: begin
        re = 1'b1;
      end
      ACT_RD_KM1: begin
        re    = 1'b1;
        raddr = AW'(k_q - One);
      end
      ACT_MV_DN: begin
        we = 1'b1;
        if (k_q - One == pos_q) begin
          wdata.delta = sat32({{2{rdata_q.delta[31]}}, rdata_q.delta} - {{2{dt_q[31]}}, dt_q});
        end
      end
      ACT_INS: begin
        we    = 1'b1;
        waddr = AW'(pos_q);
        wdata = '{id: id_q, delta: dt_q, req: amt_q};
      end
      ACT_MV_UP: begin
        we    = 1'b1;
        waddr = AW'(k_q - One);
        if (k_q == pos_q + One) begin
          wdata.delta = sat32({{2{rdata_q.delta[31]}}, rdata_q.delta} + {{2{dt_q[31]}}, dt_q});
        end
      end
      ACT_HEAD_WR: begin
        we          = 1'b1;
        waddr       = '0;
        wdata.delta = newd_q;
      end
      ACT_CMP: begin
        we    = 1'b1;
        waddr = AW'(k_q - fcnt_q);
        if (k_q == fcnt_q) begin
          wdata.delta = nhead_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prec_q      <= '0;
      op_q        <= '0;
      id_q        <= '0;
      amt_q       <= '0;
      k_q         <= '0;
      cnt_q       <= '0;
      pos_q       <= '0;
      fcnt_q      <= '0;
      dt_q        <= '0;
      newd_q      <= '0;
      nhead_q     <= '0;
      head_q      <= '0;
      found_q     <= 1'b0;
      dup_q       <= 1'b0;
      stop_q      <= 1'b0;
      hchg_q      <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= '0;
      fired_q     <= 1'b0;
      fid_q       <= '0;
      ftime_q     <= '0;
      hout_q      <= '0;
      hchg_out_q  <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        prec_q <= cfg_wdata_i;
      end
      if (we && waddr == '0) begin
        head_q <= wdata.delta;
      end
      if (cmd_i.act inside {ACT_EMIT, ACT_EMIT_F}) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.act)
        ACT_START: begin
          op_q    <= opcode_i;
          id_q    <= timer_id_i;
          amt_q   <= amount_i;
          k_q     <= '0;
          pos_q   <= '0;
          fcnt_q  <= One;
          dt_q    <= $signed({1'b0, amount_i});
          newd_q  <= newd_in;
          found_q <= 1'b0;
          dup_q   <= 1'b0;
          stop_q  <= 1'b0;
          hchg_q  <= 1'b0;
        end
        ACT_EV_SCH: begin
          if (rdata_q.id == id_q) begin
            dup_q <= 1'b1;
          end
          if (!found_q) begin
            if (dt_q > rdata_q.delta) begin
              dt_q  <= dt_q - rdata_q.delta;
              pos_q <= k_q + One;
            end else begin
              found_q <= 1'b1;
            end
          end
          k_q <= k_q + One;
        end
        ACT_EV_CAN: begin
          if (!found_q && rdata_q.id == id_q) begin
            found_q <= 1'b1;
            pos_q   <= k_q;
            dt_q    <= rdata_q.delta;
          end
          k_q <= k_q + One;
        end
        ACT_EV_FIRE: begin
          if (rdata_q.delta == 32'sd0 && 32'(k_q) < RESULT_LIMIT) begin
            fcnt_q <= fcnt_q + One;
            k_q    <= k_q + One;
          end else begin
            stop_q  <= 1'b1;
            nhead_q <= nhead_calc;
          end
        end
        ACT_K_ONE: begin
          k_q <= One;
        end
        ACT_MV_DN_PREP: begin
          k_q <= cnt_q;
        end
        ACT_MV_DN: begin
          k_q <= k_q - One;
        end
        ACT_INS: begin
          cnt_q  <= cnt_q + One;
          hchg_q <= (pos_q == '0);
        end
        ACT_MV_UP_PREP: begin
          k_q <= pos_q + One;
        end
        ACT_MV_UP: begin
          k_q <= k_q + One;
        end
        ACT_DEL: begin
          cnt_q  <= cnt_q - One;
          hchg_q <= (pos_q == '0);
        end
        ACT_HEAD_WR: begin
          hchg_q <= 1'b1;
        end
        ACT_FIRE_PREP: begin
          k_q <= '0;
        end
        ACT_EMIT: begin
          status_q    <= cmd_i.st;
          fired_q     <= 1'b0;
          fid_q       <= '0;
          ftime_q     <= '0;
          hout_q      <= (cnt_q == '0) ? -32'sd1 : head_q;
          hchg_out_q  <= hchg_q;
          last_q      <= 1'b1;
        end
        ACT_EMIT_F: begin
          status_q    <= ST_OK;
          fired_q     <= 1'b1;
          fid_q       <= rdata_q.id;
          ftime_q     <= sat32({3'b0, rdata_q.req} - {{2{newd_q[31]}}, newd_q});
          hout_q      <= (cnt_q != fcnt_q) ? nhead_q : -32'sd1;
          hchg_out_q  <= 1'b1;
          last_q      <= (k_q + One == fcnt_q);
          k_q         <= k_q + One;
        end
        ACT_CMP_PREP: begin
          k_q <= fcnt_q;
        end
        ACT_CMP: begin
          k_q <= k_q + One;
        end
        ACT_CMP_DONE: begin
          cnt_q <= cnt_q - fcnt_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    sts_o.is_sched  = (op_q == OP_SCHED);
    sts_o.is_cancel = (op_q == OP_CANCEL);
    sts_o.is_elapse = (op_q == OP_ELAPSE);
    sts_o.cnt_zero  = (cnt_q == '0);
    sts_o.full      = (cnt_q == Full);
    sts_o.dup       = dup_q;
    sts_o.found     = found_q;
    sts_o.no_fire   = (newd_q > prec_ext);
    sts_o.k_lt_cnt  = (k_q < cnt_q);
    sts_o.k_gt_pos  = (k_q > pos_q);
    sts_o.fire_done = stop_q || (k_q == cnt_q);
    sts_o.last_fire = (k_q + One == fcnt_q);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign fired_o        = fired_q;
  assign fired_id_o     = fid_q;
  assign fired_time_o   = ftime_q;
  assign head_delta_o   = hout_q;
  assign head_changed_o = hchg_out_q;
  assign last_o         = last_q;

endmodule

/* hw/rtl/dltq_ctrl.sv */
// dltq_ctrl: sequencer that walks the slot memory for schedule, cancel and elapse
// issues commands to dltq_dpath; depends on dltq_pkg
module dltq_ctrl import dltq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_DISP      = 5'd1;
  localparam logic [4:0] S_SC_RD     = 5'd2;
  localparam logic [4:0] S_SC_EV     = 5'd3;
  localparam logic [4:0] S_SC_END    = 5'd4;
  localparam logic [4:0] S_DN_CHK    = 5'd5;
  localparam logic [4:0] S_DN_WR     = 5'd6;
  localparam logic [4:0] S_CN_RD     = 5'd7;
  localparam logic [4:0] S_CN_EV     = 5'd8;
  localparam logic [4:0] S_CN_END    = 5'd9;
  localparam logic [4:0] S_UP_CHK    = 5'd10;
  localparam logic [4:0] S_UP_WR     = 5'd11;
  localparam logic [4:0] S_HD_RD     = 5'd12;
  localparam logic [4:0] S_HD_WR     = 5'd13;
  localparam logic [4:0] S_FZ_CHK    = 5'd14;
  localparam logic [4:0] S_FZ_EV     = 5'd15;
  localparam logic [4:0] S_FE_RD     = 5'd16;
  localparam logic [4:0] S_FE_EM     = 5'd17;
  localparam logic [4:0] S_CP_PREP   = 5'd18;
  localparam logic [4:0] S_CP_CHK    = 5'd19;
  localparam logic [4:0] S_CP_WR     = 5'd20;
  localparam logic [4:0] S_EMIT      = 5'd21;
  localparam logic [4:0] S_EMIT_DUP  = 5'd22;
  localparam logic [4:0] S_EMIT_FULL = 5'd23;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.act  = ACT_NONE;
    cmd_o.st   = ST_OK;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.act = ACT_START;
          state_d   = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.is_sched) begin
          state_d = S_SC_RD;
        end else if (sts_i.is_cancel && !sts_i.cnt_zero) begin
          state_d = S_CN_RD;
        end else if (sts_i.is_elapse && !sts_i.cnt_zero) begin
          if (sts_i.no_fire) begin
            state_d = S_HD_RD;
          end else begin
            cmd_o.act = ACT_K_ONE;
            state_d   = S_FZ_CHK;
          end
        end else begin
          state_d = S_EMIT;
        end
      end
      S_SC_RD: begin
        if (sts_i.k_lt_cnt) begin
          cmd_o.act = ACT_RD_K;
          state_d   = S_SC_EV;
        end else begin
          state_d = S_SC_END;
        end
      end
      S_SC_EV: begin
        cmd_o.act = ACT_EV_SCH;
        state_d   = S_SC_RD;
      end
      S_SC_END: begin
        if (sts_i.dup) begin
          state_d = S_EMIT_DUP;
        end else if (sts_i.full) begin
          state_d = S_EMIT_FULL;
        end else begin
          cmd_o.act = ACT_MV_DN_PREP;
          state_d   = S_DN_CHK;
        end
      end
      S_DN_CHK: begin
        if (sts_i.k_gt_pos) begin
          cmd_o.act = ACT_RD_KM1;
          state_d   = S_DN_WR;
        end else begin
          cmd_o.act = ACT_INS;
          state_d   = S_EMIT;
        end
      end
      S_DN_WR: begin
        cmd_o.act = ACT_MV_DN;
        state_d   = S_DN_CHK;
      end
      S_CN_RD: begin
        if (sts_i.k_lt_cnt) begin
          cmd_o.act = ACT_RD_K;
          state_d   = S_CN_EV;
        end else begin
          state_d = S_CN_END;
        end
      end
      S_CN_EV: begin
        cmd_o.act = ACT_EV_CAN;
        state_d   = S_CN_RD;
      end
      S_CN_END: begin
        if (sts_i.found) begin
          cmd_o.act = ACT_MV_UP_PREP;
          state_d   = S_UP_CHK;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_UP_CHK: begin
        if (sts_i.k_lt_cnt) begin
          cmd_o.act = ACT_RD_K;
          state_d   = S_UP_WR;
        end else begin
          cmd_o.act = ACT_DEL;
          state_d   = S_EMIT;
        end
      end
      S_UP_WR: begin
        cmd_o.act = ACT_MV_UP;
        state_d   = S_UP_CHK;
      end
      S_HD_RD: begin
        cmd_o.act = ACT_RD_K;
        state_d   = S_HD_WR;
      end
      S_HD_WR: begin
        cmd_o.act = ACT_HEAD_WR;
        state_d   = S_EMIT;
      end
      S_FZ_CHK: begin
        if (sts_i.fire_done) begin
          cmd_o.act = ACT_FIRE_PREP;
          state_d   = S_FE_RD;
        end else begin
          cmd_o.act = ACT_RD_K;
          state_d   = S_FZ_EV;
        end
      end
      S_FZ_EV: begin
        cmd_o.act = ACT_EV_FIRE;
        state_d   = S_FZ_CHK;
      end
      S_FE_RD: begin
        cmd_o.act = ACT_RD_K;
        state_d   = S_FE_EM;
      end
      S_FE_EM: begin
        if (sts_i.out_free) begin
          cmd_o.act = ACT_EMIT_F;
          state_d   = sts_i.last_fire ? S_CP_PREP : S_FE_RD;
        end
      end
      S_CP_PREP: begin
        cmd_o.act = ACT_CMP_PREP;
        state_d   = S_CP_CHK;
      end
      S_CP_CHK: begin
        if (sts_i.k_lt_cnt) begin
          cmd_o.act = ACT_RD_K;
          state_d   = S_CP_WR;
        end else begin
          cmd_o.act = ACT_CMP_DONE;
          state_d   = S_IDLE;
        end
      end
      S_CP_WR: begin
        cmd_o.act = ACT_CMP;
        state_d   = S_CP_CHK;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.act = ACT_EMIT;
          state_d   = S_IDLE;
        end
      end
      S_EMIT_DUP: begin
        cmd_o.st = ST_DUP;
        if (sts_i.out_free) begin
          cmd_o.act = ACT_EMIT;
          state_d   = S_IDLE;
        end
      end
      S_EMIT_FULL: begin
        cmd_o.st = ST_FULL;
        if (sts_i.out_free) begin
          cmd_o.act = ACT_EMIT;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/delta_list_timer_queue_unit.sv */
// delta_list_timer_queue_unit: top level of the sorted delta list timer queue
// instantiates dltq_ctrl and dltq_dpath; depends on dltq_pkg
//
// usage: one request enters on the in channel (opcode, timer_id, amount) with
// valid/ready; results leave on the out channel with valid/ready, one per
// request or one per fired timer, the final one flagged by last.
// precision must be written through cfg_we_i/cfg_wdata_i only while the block
// is idle; the block itself does not enforce this. requests are handled one at
// a time, walking the slot memory entry by entry through its single read port.
// at reset the queue is empty and precision is zero; no clearing pass.
// a stalled receiver holds the result register; the sequencer waits at its
// next result, and in_ready stays low until the request is fully done.
module delta_list_timer_queue_unit import dltq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [3:0]         timer_id_i,
  input  logic [30:0]        amount_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic               fired_o,
  output logic [3:0]         fired_id_o,
  output logic signed [31:0] fired_time_o,
  output logic signed [31:0] head_delta_o,
  output logic               head_changed_o,
  output logic               last_o
);

  cmd_t cmd;
  sts_t sts;

  dltq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dltq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .opcode_i       (opcode_i),
    .timer_id_i     (timer_id_i),
    .amount_i       (amount_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .fired_o        (fired_o),
    .fired_id_o     (fired_id_o),
    .fired_time_o   (fired_time_o),
    .head_delta_o   (head_delta_o),
    .head_changed_o (head_changed_o),
    .last_o         (last_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while previous one in flight");

  a_fired_changes_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fired_o) |-> (head_changed_o && status_o == ST_OK))
    else $error("fired result without head change");

  a_reject_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (last_o && !fired_o && !head_changed_o))
    else $error("rejected schedule not a single plain result");
`endif

endmodule

/* tb/tb_delta_list_timer_queue_unit.sv */
// tb_delta_list_timer_queue_unit: self-checking bench for the delta list timer queue
// directed table then random requests, results checked against an in-bench queue predictor
// depends on dltq_pkg and delta_list_timer_queue_unit
`timescale 1ns / 1ps

module tb_delta_list_timer_queue_unit import dltq_pkg::*; ();

  localparam int DEPTH = 16;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam longint MAX32 = 64'sd2147483647;
  localparam longint MIN32 = -64'sd2147483648;
  localparam logic [30:0] AMT_MAX = 31'h7FFFFFFF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE = 100;

  typedef struct packed {
    logic [1:0]         status;
    logic               fired;
    logic [3:0]         fired_id;
    logic signed [31:0] fired_time;
    logic signed [31:0] head_delta;
    logic               head_changed;
    logic               last;
  } timer_result_t;

  typedef struct {
    logic [1:0]  op;
    logic [3:0]  id;
    logic [30:0] amt;
    bit          typed;
    logic [1:0]  want_status;
    logic signed [31:0] want_head;
  } table_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [15:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         opcode_i = '0;
  logic [3:0]         timer_id_i = '0;
  logic [30:0]        amount_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         status_o;
  logic               fired_o;
  logic [3:0]         fired_id_o;
  logic signed [31:0] fired_time_o;
  logic signed [31:0] head_delta_o;
  logic               head_changed_o;
  logic               last_o;

  logic [3:0]  slot_ids [DEPTH];
  longint      slot_deltas [DEPTH];
  longint      slot_reqs [DEPTH];
  int          queued;
  logic [15:0] precision;

  timer_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  table_row_t rows[$];

  delta_list_timer_queue_unit #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .opcode_i, .timer_id_i, .amount_i,
    .out_valid_o, .out_ready_i, .status_o, .fired_o, .fired_id_o,
    .fired_time_o, .head_delta_o, .head_changed_o, .last_o
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_delta_list_timer_queue_unit failed");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic longint sat(input longint v);
    if (v > MAX32) return MAX32;
    if (v < MIN32) return MIN32;
    return v;
  endfunction

  function automatic timer_result_t make_result(input logic [1:0] st, input logic f,
                                                input logic [3:0] fid, input longint ft,
                                                input logic chg);
    timer_result_t r;
    r.status = st;
    r.fired = f;
    r.fired_id = fid;
    r.fired_time = 32'(sat(ft));
    r.head_delta = '0;
    r.head_changed = chg;
    r.last = 1'b0;
    return r;
  endfunction

  // apply one request to the queue copy and return its results
  task automatic predict_timers(input logic [1:0] op, input logic [3:0] id,
                                input logic [30:0] amt, output timer_result_t res[$]);
    int pos;
    int cnt;
    bit dup;
    longint dt;
    longint newd;
    longint head;
    res = {};
    if (op == OP_SCHED) begin
      dup = 0;
      for (int k = 0; k < queued; k++) if (slot_ids[k] == id) dup = 1;
      if (dup) begin
        res = {res, make_result(ST_DUP, 0, 0, 0, 0)};
      end else if (queued >= DEPTH) begin
        res = {res, make_result(ST_FULL, 0, 0, 0, 0)};
      end else begin
        pos = 0;
        dt = amt;
        while (pos < queued && dt > slot_deltas[pos]) begin
          dt -= slot_deltas[pos];
          pos++;
        end
        for (int k = queued; k > pos; k--) begin
          slot_ids[k] = slot_ids[k-1];
          slot_deltas[k] = slot_deltas[k-1];
          slot_reqs[k] = slot_reqs[k-1];
        end
        slot_ids[pos] = id;
        slot_deltas[pos] = dt;
        slot_reqs[pos] = amt;
        queued++;
        if (pos + 1 < queued) slot_deltas[pos+1] = sat(slot_deltas[pos+1] - dt);
        res = {res, make_result(ST_OK, 0, 0, 0, pos == 0)};
      end
    end else if (op == OP_CANCEL) begin
      pos = 0;
      while (pos < queued && slot_ids[pos] != id) pos++;
      if (pos >= queued) begin
        res = {res, make_result(ST_OK, 0, 0, 0, 0)};
      end else begin
        dt = slot_deltas[pos];
        for (int k = pos; k < queued - 1; k++) begin
          slot_ids[k] = slot_ids[k+1];
          slot_deltas[k] = slot_deltas[k+1];
          slot_reqs[k] = slot_reqs[k+1];
        end
        queued--;
        if (pos < queued) slot_deltas[pos] = sat(slot_deltas[pos] + dt);
        res = {res, make_result(ST_OK, 0, 0, 0, pos == 0)};
      end
    end else if (op == OP_ELAPSE) begin
      if (queued == 0) begin
        res = {res, make_result(ST_OK, 0, 0, 0, 0)};
      end else begin
        newd = sat(slot_deltas[0] - amt);
        if (newd > longint'(precision)) begin
          slot_deltas[0] = newd;
          res = {res, make_result(ST_OK, 0, 0, 0, 1)};
        end else begin
          cnt = 1;
          while (cnt < queued && cnt < RESULT_LIMIT && slot_deltas[cnt] == 0) cnt++;
          for (int k = 0; k < cnt; k++)
            res = {res, make_result(ST_OK, 1, slot_ids[k], slot_reqs[k] - newd, 1)};
          for (int k = 0; k < queued - cnt; k++) begin
            slot_ids[k] = slot_ids[k+cnt];
            slot_deltas[k] = slot_deltas[k+cnt];
            slot_reqs[k] = slot_reqs[k+cnt];
          end
          queued -= cnt;
          if (queued > 0) begin
            dt = slot_deltas[0] + newd;
            slot_deltas[0] = dt < 0 ? 0 : sat(dt);
          end
        end
      end
    end else begin
      res = {res, make_result(ST_OK, 0, 0, 0, 0)};
    end
    head = queued > 0 ? slot_deltas[0] : -1;
    foreach (res[j]) res[j].head_delta = 32'(head);
    res[res.size()-1].last = 1'b1;
  endtask

  task automatic send_request(input logic [1:0] op, input logic [3:0] id,
                              input logic [30:0] amt, output timer_result_t res[$]);
    in_valid_i <= 1'b1;
    opcode_i <= op;
    timer_id_i <= id;
    amount_i <= amt;
    do @(posedge clk_i); while (!in_ready_o);
    predict_timers(op, id, amt, res);
    foreach (res[j]) pending_results = {pending_results, res[j]};
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_precision(input logic [15:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    precision = value;
  endtask

  function automatic logic [30:0] pick_amount();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return 31'($urandom_range(40));
    if (sel < 75) return 31'($urandom_range(400));
    if (sel < 82) return '0;
    if (sel < 90) return AMT_MAX - 31'($urandom_range(3));
    return 31'($urandom);
  endfunction

  task automatic random_phase(input int count);
    timer_result_t res[$];
    int sel;
    logic [1:0] op;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 42) op = OP_SCHED;
      else if (sel < 62) op = OP_CANCEL;
      else if (sel < 96) op = OP_ELAPSE;
      else op = OP_NONE;
      send_request(op, 4'($urandom_range(15)), pick_amount(), res);
    end
  endtask

  function automatic table_row_t row(input logic [1:0] op, input logic [3:0] id,
                                     input logic [30:0] amt, input bit typed = 0,
                                     input logic [1:0] st = ST_OK,
                                     input logic signed [31:0] head = 0);
    table_row_t r;
    r.op = op; r.id = id; r.amt = amt; r.typed = typed;
    r.want_status = st; r.want_head = head;
    return r;
  endfunction

  always @(posedge clk_i) begin
    timer_result_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) report("status", status_o, want.status);
        if (fired_o !== want.fired) report("fired", fired_o, want.fired);
        if (fired_id_o !== want.fired_id) report("fired_id", fired_id_o, want.fired_id);
        if (fired_time_o !== want.fired_time)
          report("fired_time", fired_time_o, want.fired_time);
        if (head_delta_o !== want.head_delta)
          report("head_delta", head_delta_o, want.head_delta);
        if (head_changed_o !== want.head_changed)
          report("head_changed", head_changed_o, want.head_changed);
        if (last_o !== want.last) report("last", last_o, want.last);
      end
    end
    out_ready_i <= ($urandom_range(99) < recv_stall_pct) ? 1'b0 : 1'b1;
  end

  initial begin
    timer_result_t res[$];
    queued = 0;
    precision = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue cases, duplicate, equal delays, mass expiry, extremes
    rows = {rows, row(OP_ELAPSE, 4'd0, 31'd5, 1, ST_OK, -1)};
    rows = {rows, row(OP_CANCEL, 4'd3, 31'd0, 1, ST_OK, -1)};
    rows = {rows, row(OP_NONE, 4'd15, AMT_MAX, 1, ST_OK, -1)};
    rows = {rows, row(OP_SCHED, 4'd0, 31'd0, 1, ST_OK, 0)};
    rows = {rows, row(OP_SCHED, 4'd0, 31'd9, 1, ST_DUP, 0)};
    rows = {rows, row(OP_ELAPSE, 4'd0, 31'd0, 1, ST_OK, -1)};
    for (int k = 0; k < DEPTH; k++) rows = {rows, row(OP_SCHED, 4'(k), 31'd7)};
    rows = {rows, row(OP_ELAPSE, 4'd0, 31'd7)};
    rows = {rows, row(OP_SCHED, 4'd5, AMT_MAX)};
    rows = {rows, row(OP_SCHED, 4'd6, 31'd3)};
    rows = {rows, row(OP_CANCEL, 4'd6, 31'd0)};
    rows = {rows, row(OP_ELAPSE, 4'd0, AMT_MAX)};

    set_precision(16'd0);
    foreach (rows[i]) begin
      send_request(rows[i].op, rows[i].id, rows[i].amt, res);
      if (rows[i].typed) begin
        if (res[0].status !== rows[i].want_status)
          report("table status", res[0].status, rows[i].want_status);
        if (res[0].head_delta !== rows[i].want_head)
          report("table head_delta", res[0].head_delta, rows[i].want_head);
      end
    end

    set_precision(16'hFFFF);
    random_phase(90);
    send_idle_pct = 68;
    set_precision(16'($urandom_range(50)));
    random_phase(90);
    send_idle_pct = 0;
    recv_stall_pct = 68;
    set_precision(16'd0);
    random_phase(90);
    send_idle_pct = 26;
    recv_stall_pct = 26;
    set_precision(16'($urandom));
    random_phase(90);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_precision(16'd3);
    random_phase(85);

    drain();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_delta_list_timer_queue_unit passed");
    end else begin
      $display("tb_delta_list_timer_queue_unit failed");
    end
    $finish;
  end

endmodule
